### hdl/olms_pkg.sv
package olms_pkg;

  // Sine resolution: the angle is quantised to this many steps per turn
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int ANGLE_IDX_BITS   = $clog2(SINE_TABLE_DEPTH);
  localparam logic [31:0] ANGLE_QUANT_MASK =
    ~((32'd1 << (32 - ANGLE_IDX_BITS)) - 32'd1);

  // Serial multiplier: 16-bit multiplier operand, one bit per cycle
  localparam int MUL_BITS  = 16;
  localparam int MUL_CNT_W = $clog2(MUL_BITS);
  localparam int MCAND_W   = 49;

  // Ramp divider: 48-bit magnitude, one quotient bit per cycle
  localparam int DIV_W     = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Rotation engine
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS);
  localparam int CORDIC_W     = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

  // Phase codes
  localparam logic [1:0] PH_ALIGN = 2'd0;
  localparam logic [1:0] PH_RAMP  = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_VOLTAGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_VOLTAGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPEED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_DUR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DUR      = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAMP_GO,
    ST_RAMP_MUL,
    ST_RAMP_DIV,
    ST_RAMP_END,
    ST_ANG_GO,
    ST_ANG_MUL,
    ST_CORD_GO,
    ST_CORD_RUN,
    ST_SIN_GO,
    ST_SIN_MUL,
    ST_COS_GO,
    ST_COS_MUL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                      start;
    logic                      msb_neg;
    logic signed [MCAND_W-1:0] mcand;
    logic [MUL_BITS-1:0]       mplier;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cordic_req_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [CORDIC_CNT_W-1:0] i);
    case (i)
      4'd0:    atan_turn = 32'd536870912;
      4'd1:    atan_turn = 32'd316933406;
      4'd2:    atan_turn = 32'd167458907;
      4'd3:    atan_turn = 32'd85004756;
      4'd4:    atan_turn = 32'd42667331;
      4'd5:    atan_turn = 32'd21354465;
      4'd6:    atan_turn = 32'd10679838;
      4'd7:    atan_turn = 32'd5340245;
      4'd8:    atan_turn = 32'd2670163;
      4'd9:    atan_turn = 32'd1335087;
      4'd10:   atan_turn = 32'd667544;
      4'd11:   atan_turn = 32'd333772;
      4'd12:   atan_turn = 32'd166886;
      4'd13:   atan_turn = 32'd83443;
      4'd14:   atan_turn = 32'd41721;
      default: atan_turn = 32'd20861;
    endcase
  endfunction

endpackage

### hdl/open_loop_motor_startup.sv
// Each accepted tick runs to out_valid: align goes straight to the rotation, run
// or a zero ramp time first does the angle multiply, and ramping also does the
// ramp multiply and the 48-bit bit-serial divider. One tick is in flight at a
// time; the next is taken the cycle after the result enters the output register,
// which waits while a stalled result still occupies that register.
// rst_n (synchronous) clears configuration to zero and puts the sequencer in align.
module open_loop_motor_startup (
  input  logic                 clk,
  input  logic                 rst_n,
  // tick / restart requests
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic [15:0]          in_elapsed_ms,
  // voltage command results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_volt_alpha,
  output logic signed [15:0]   out_volt_beta,
  output logic [15:0]          out_rotor_angle,
  output logic [31:0]          out_rotor_speed,
  output logic [1:0]           out_run_phase,
  // configuration writes
  input  logic                 cfg_wr_en,
  input  logic [olms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);
  import olms_pkg::*;

  // Configuration
  logic [15:0] align_voltage_r;
  logic [15:0] drive_voltage_r;
  logic [31:0] startup_speed_r;
  logic [31:0] target_speed_r;
  logic [15:0] align_dur_r;
  logic [15:0] ramp_dur_r;

  // Sequencer state
  state_t      state_r, state_nxt;
  logic [1:0]  phase_r;
  logic [31:0] angle_r;
  logic [31:0] speed_r;
  logic [31:0] pe_r;

  // Per-request working registers
  logic [15:0]          dt_r;
  logic [15:0]          p_r;
  logic signed [15:0]   volt_r;
  logic [DIV_W-1:0]     div_num_r;
  logic [15:0]          div_rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                 div_neg_r;
  logic signed [15:0]   alpha_r;
  logic signed [15:0]   beta_r;

  // Output register
  logic                 out_valid_r;
  logic signed [15:0]   out_alpha_r;
  logic signed [15:0]   out_beta_r;
  logic [15:0]          out_angle_r;
  logic [31:0]          out_speed_r;
  logic [1:0]           out_phase_r;

  // Arithmetic units
  mul_req_t                  mul_req;
  logic                      mul_done;
  logic signed [MCAND_W-1:0] mul_prod;
  cordic_req_t               cord_req;
  logic                      cord_done;
  logic signed [15:0]        cord_sin;
  logic signed [15:0]        cord_cos;

  // Combinational helpers
  logic                      accept;
  logic                      tick_go;
  logic [32:0]               pe_sum;
  logic [31:0]               pe_sat;
  logic                      align_done;
  logic                      ramp_done;
  logic [15:0]               p_min;
  logic signed [32:0]        speed_diff;
  logic signed [MCAND_W-1:0] prod_abs;
  logic [16:0]               rem_sh;
  logic                      rem_ge;
  logic [31:0]               ramp_step;
  logic                      out_load;

  // V*s product to Q15: half-LSB bias, floor shift, saturate to 16 bits
  function automatic logic signed [15:0] scale_round(input logic signed [MCAND_W-1:0] v);
    logic signed [MCAND_W-1:0] t;
    t = (v + MCAND_W'(16384)) >>> 15;
    if (t > MCAND_W'(32767))
      scale_round = 16'sh7fff;
    else if (t < -MCAND_W'(32768))
      scale_round = 16'sh8000;
    else
      scale_round = t[15:0];
  endfunction

  olms_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  olms_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (cord_req),
    .done    (cord_done),
    .sin_q15 (cord_sin),
    .cos_q15 (cord_cos)
  );

  // Request intake: only while idle
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign tick_go  = accept && !in_mode && (in_elapsed_ms != 16'd0);

  // Saturating phase timer and phase-end tests, all on the post-tick count
  always_comb begin
    pe_sum     = {1'b0, pe_r} + {17'd0, in_elapsed_ms};
    pe_sat     = pe_sum[32] ? 32'hffff_ffff : pe_sum[31:0];
    align_done = (pe_sat >= {16'd0, align_dur_r});
    ramp_done  = (pe_sat >= {16'd0, ramp_dur_r});
    p_min      = ramp_done ? ramp_dur_r : pe_sat[15:0];
    speed_diff = signed'({1'b0, target_speed_r}) - signed'({1'b0, startup_speed_r});
  end

  // Divider step: restoring, one quotient bit shifted into the numerator word
  always_comb begin
    prod_abs  = mul_prod[MCAND_W-1] ? -mul_prod : mul_prod;
    rem_sh    = {div_rem_r, div_num_r[DIV_W-1]};
    rem_ge    = (rem_sh >= {1'b0, ramp_dur_r});
    ramp_step = div_neg_r ? (32'd0 - div_num_r[31:0]) : div_num_r[31:0];
  end

  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  // Next state and unit launches
  always_comb begin
    state_nxt        = state_r;
    mul_req.start    = 1'b0;
    mul_req.msb_neg  = 1'b0;
    mul_req.mcand    = '0;
    mul_req.mplier   = '0;
    cord_req.start   = 1'b0;
    cord_req.angle   = angle_r & ANGLE_QUANT_MASK;
    case (state_r)
      ST_IDLE: begin
        if (tick_go) begin
          if (phase_r == PH_ALIGN)
            state_nxt = ST_CORD_GO;
          else if (phase_r == PH_RAMP && ramp_dur_r != 16'd0)
            state_nxt = ST_RAMP_GO;
          else
            state_nxt = ST_ANG_GO;
        end
      end
      ST_RAMP_GO: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = MCAND_W'(speed_diff);
        mul_req.mplier = p_r;
        state_nxt      = ST_RAMP_MUL;
      end
      ST_RAMP_MUL: begin
        if (mul_done)
          state_nxt = ST_RAMP_DIV;
      end
      ST_RAMP_DIV: begin
        if (div_cnt_r == DIV_CNT_W'(DIV_W - 1))
          state_nxt = ST_RAMP_END;
      end
      ST_RAMP_END: begin
        state_nxt = ST_ANG_GO;
      end
      ST_ANG_GO: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = MCAND_W'(signed'({1'b0, speed_r}));
        mul_req.mplier = dt_r;
        state_nxt      = ST_ANG_MUL;
      end
      ST_ANG_MUL: begin
        if (mul_done)
          state_nxt = ST_CORD_GO;
      end
      ST_CORD_GO: begin
        cord_req.start = 1'b1;
        state_nxt      = ST_CORD_RUN;
      end
      ST_CORD_RUN: begin
        if (cord_done)
          state_nxt = ST_SIN_GO;
      end
      ST_SIN_GO: begin
        mul_req.start   = 1'b1;
        mul_req.msb_neg = 1'b1;
        mul_req.mcand   = MCAND_W'(cord_sin);
        mul_req.mplier  = volt_r;
        state_nxt       = ST_SIN_MUL;
      end
      ST_SIN_MUL: begin
        if (mul_done)
          state_nxt = ST_COS_GO;
      end
      ST_COS_GO: begin
        mul_req.start   = 1'b1;
        mul_req.msb_neg = 1'b1;
        mul_req.mcand   = MCAND_W'(cord_cos);
        mul_req.mplier  = volt_r;
        state_nxt       = ST_COS_MUL;
      end
      ST_COS_MUL: begin
        if (mul_done)
          state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (out_load)
          state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= ST_IDLE;
    else
      state_r <= state_nxt;
  end

  // Configuration and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_voltage_r <= '0;
      drive_voltage_r <= '0;
      startup_speed_r <= '0;
      target_speed_r  <= '0;
      align_dur_r     <= '0;
      ramp_dur_r      <= '0;
      phase_r         <= PH_ALIGN;
      angle_r         <= '0;
      speed_r         <= '0;
      pe_r            <= '0;
      div_cnt_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ALIGN_VOLTAGE: align_voltage_r <= cfg_wdata[15:0];
          CFG_DRIVE_VOLTAGE: drive_voltage_r <= cfg_wdata[15:0];
          CFG_STARTUP_SPEED: startup_speed_r <= cfg_wdata;
          CFG_TARGET_SPEED:  target_speed_r  <= cfg_wdata;
          CFG_ALIGN_DUR:     align_dur_r     <= cfg_wdata[15:0];
          CFG_RAMP_DUR:      ramp_dur_r      <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      // Restart: drop back to align with the start-up speed preloaded
      if (accept && in_mode) begin
        phase_r <= PH_ALIGN;
        pe_r    <= '0;
        angle_r <= '0;
        speed_r <= startup_speed_r;
      end

      if (tick_go) begin
        case (phase_r)
          PH_ALIGN: begin
            angle_r <= '0;
            speed_r <= '0;
            if (align_done) begin
              phase_r <= PH_RAMP;
              pe_r    <= '0;
            end else begin
              pe_r <= pe_sat;
            end
          end
          PH_RAMP: begin
            pe_r <= pe_sat;
            if (ramp_dur_r == 16'd0) begin
              speed_r <= target_speed_r;
              phase_r <= PH_RUN;
            end else if (ramp_done) begin
              phase_r <= PH_RUN;
            end
          end
          default: begin
            // run, and the unused code behaves as run
            pe_r    <= pe_sat;
            phase_r <= PH_RUN;
            speed_r <= target_speed_r;
          end
        endcase
      end

      if (state_r == ST_RAMP_MUL && mul_done)
        div_cnt_r <= '0;
      else if (state_r == ST_RAMP_DIV)
        div_cnt_r <= div_cnt_r + 1'b1;

      if (state_r == ST_RAMP_END)
        speed_r <= startup_speed_r + ramp_step;

      // Advance the turn accumulator by speed * elapsed, wrapping
      if (state_r == ST_ANG_MUL && mul_done)
        angle_r <= angle_r + mul_prod[31:0];

      if (out_load)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;
    end
  end

  // Working registers and the output snapshot
  always_ff @(posedge clk) begin
    if (tick_go) begin
      dt_r   <= in_elapsed_ms;
      p_r    <= p_min;
      volt_r <= (phase_r == PH_ALIGN) ? signed'(align_voltage_r) : signed'(drive_voltage_r);
    end

    if (state_r == ST_RAMP_MUL && mul_done) begin
      div_neg_r <= mul_prod[MCAND_W-1];
      div_num_r <= prod_abs[DIV_W-1:0];
      div_rem_r <= '0;
    end else if (state_r == ST_RAMP_DIV) begin
      div_rem_r <= rem_ge ? 16'(rem_sh - {1'b0, ramp_dur_r}) : rem_sh[15:0];
      div_num_r <= {div_num_r[DIV_W-2:0], rem_ge};
    end

    // alpha is the negated sine term; the one value with no positive twin maps to max
    if (state_r == ST_SIN_MUL && mul_done) begin
      if (scale_round(mul_prod) == 16'sh8000)
        alpha_r <= 16'sh7fff;
      else
        alpha_r <= -scale_round(mul_prod);
    end

    if (state_r == ST_COS_MUL && mul_done)
      beta_r <= scale_round(mul_prod);

    if (out_load) begin
      out_alpha_r <= alpha_r;
      out_beta_r  <= beta_r;
      out_angle_r <= angle_r[31:16];
      out_speed_r <= speed_r;
      out_phase_r <= phase_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_volt_alpha  = out_alpha_r;
  assign out_volt_beta   = out_beta_r;
  assign out_rotor_angle = out_angle_r;
  assign out_rotor_speed = out_speed_r;
  assign out_run_phase   = out_phase_r;

endmodule

### hdl/olms_serial_mul.sv
module olms_serial_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  olms_pkg::mul_req_t                req,
  output logic                              done,
  output logic signed [olms_pkg::MCAND_W-1:0] prod
);
  import olms_pkg::*;

  logic                      busy_r;
  logic                      done_r;
  logic [MUL_CNT_W-1:0]      cnt_r;
  logic                      neg_r;
  logic signed [MCAND_W-1:0] mcand_r;
  logic [MUL_BITS-1:0]       mplier_r;
  logic signed [MCAND_W-1:0] prod_r;

  logic                      last;
  logic signed [MCAND_W-1:0] addend;
  logic signed [MCAND_W-1:0] prod_nxt;

  // Top multiplier bit carries negative weight for a signed multiplier
  always_comb begin
    last     = (cnt_r == MUL_CNT_W'(MUL_BITS - 1));
    addend   = (last && neg_r) ? -mcand_r : mcand_r;
    prod_nxt = mplier_r[0] ? (prod_r + addend) : prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand_r  <= req.mcand;
      mplier_r <= req.mplier;
      neg_r    <= req.msb_neg;
      prod_r   <= '0;
    end else if (busy_r) begin
      prod_r   <= prod_nxt;
      mcand_r  <= mcand_r <<< 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

### hdl/olms_cordic.sv
module olms_cordic (
  input  logic                   clk,
  input  logic                   rst_n,
  input  olms_pkg::cordic_req_t  req,
  output logic                   done,
  output logic signed [15:0]     sin_q15,
  output logic signed [15:0]     cos_q15
);
  import olms_pkg::*;

  logic                       busy_r;
  logic                       done_r;
  logic [CORDIC_CNT_W-1:0]    iter_r;
  logic signed [CORDIC_W-1:0] x_r;
  logic signed [CORDIC_W-1:0] y_r;
  logic signed [31:0]         z_r;
  logic [1:0]                 quad_r;

  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic signed [31:0]         at;
  logic signed [CORDIC_W-1:0] x_nxt;
  logic signed [CORDIC_W-1:0] y_nxt;
  logic signed [31:0]         z_nxt;
  logic signed [15:0]         c_q;
  logic signed [15:0]         s_q;

  // Round Q30 to Q15 toward minus infinity after a half-LSB bias, clamp symmetric
  function automatic logic signed [15:0] q30_to_q15(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] t;
    t = (v + CORDIC_W'(16384)) >>> 15;
    if (t > CORDIC_W'(32767))
      q30_to_q15 = 16'sd32767;
    else if (t < -CORDIC_W'(32767))
      q30_to_q15 = -16'sd32767;
    else
      q30_to_q15 = t[15:0];
  endfunction

  always_comb begin
    xs = x_r >>> iter_r;
    ys = y_r >>> iter_r;
    at = signed'(atan_turn(iter_r));
    if (!z_r[31]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
      end else if (busy_r) begin
        iter_r <= iter_r + 1'b1;
        if (iter_r == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r    <= CORDIC_X0;
      y_r    <= '0;
      z_r    <= {2'b00, req.angle[29:0]};
      quad_r <= req.angle[31:30];
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  // Fold the quarter-turn result back to the full circle
  always_comb begin
    c_q = q30_to_q15(x_r);
    s_q = q30_to_q15(y_r);
    case (quad_r)
      2'd0: begin
        cos_q15 = c_q;
        sin_q15 = s_q;
      end
      2'd1: begin
        cos_q15 = -s_q;
        sin_q15 = c_q;
      end
      2'd2: begin
        cos_q15 = -c_q;
        sin_q15 = -s_q;
      end
      default: begin
        cos_q15 = s_q;
        sin_q15 = -c_q;
      end
    endcase
  end

  assign done = done_r;

endmodule

### hdl/olms_checker.sv
module olms_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 in_mode,
  input logic [15:0]          in_elapsed_ms,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic signed [15:0]   out_volt_alpha,
  input logic signed [15:0]   out_volt_beta,
  input logic [15:0]          out_rotor_angle,
  input logic [31:0]          out_rotor_speed,
  input logic [1:0]           out_run_phase
);
  import olms_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its voltages and speed
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_volt_alpha) && $stable(out_volt_beta)
      && $stable(out_rotor_speed))
    else $error("stalled result changed");

  // A real tick occupies the sequencer on the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_mode && in_elapsed_ms != 16'd0 |=> in_stall)
    else $error("tick accepted without going busy");

  // Align keeps the rotor parked and never reports an unused phase
  a_align_parked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_phase == PH_ALIGN |-> out_rotor_angle == 16'd0
      && out_rotor_speed == 32'd0)
    else $error("rotor moving in align");

  a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_phase != 2'd3)
    else $error("unused phase code reported");

endmodule

bind open_loop_motor_startup olms_checker u_olms_checker (.*);
